[hdl/tavp_pkg.sv]
package tavp_pkg;

  // Field widths of the input and result items.
  localparam int AxisW  = 13;
  localparam int MagW   = 13;
  localparam int MmsW   = 19;
  localparam int SrcW   = 8;
  localparam int PosW   = 8;

  // Configuration register widths and indexes.
  localparam int LenW     = 9;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CfgWindowLength = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTriggerMask  = 1'd1;
  localparam logic [LenW-1:0]    WindowLengthRst = 9'd256;
  localparam logic [SrcW-1:0]    TriggerMaskRst  = 8'h40;

  // Longest window; longer programmed lengths saturate to it.
  localparam int MaxWindow = 256;

  // Input item kinds.
  localparam logic CmdTap    = 1'b0;
  localparam logic CmdSample = 1'b1;

  // Sum of three squares of a 13-bit axis is at most 3 * 2^24, so 26 bits.
  localparam int SumW = 2 * AxisW;
  localparam int StepCntW = 4;
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(AxisW - 1);

  // LSB to mm/s^2: (lsb * 39164 + 512) >> 10.
  localparam int MmsFactorW = 16;
  localparam logic [MmsFactorW-1:0] MmsFactor = 16'd39164;
  localparam int MmsShift   = 10;
  localparam int ProdW      = MagW + MmsFactorW;

  // Status of the magnitude unit toward its user.
  typedef struct packed {
    logic            done;
    logic [MagW-1:0] root;
  } mag_status_t;

endpackage

[hdl/tavp_if.sv]
interface tavp_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     cmd;
  logic        [tavp_pkg::SrcW-1:0]         irq_src;
  logic signed [tavp_pkg::AxisW-1:0]        sample_x;
  logic signed [tavp_pkg::AxisW-1:0]        sample_y;
  logic signed [tavp_pkg::AxisW-1:0]        sample_z;

  modport source (output valid, cmd, irq_src, sample_x, sample_y, sample_z, input ready);
  modport sink   (input valid, cmd, irq_src, sample_x, sample_y, sample_z, output ready);
endinterface

interface tavp_out_if;
  logic                          valid;
  logic                          ready;
  logic [tavp_pkg::MagW-1:0]     magnitude;
  logic [tavp_pkg::MmsW-1:0]     magnitude_mms2;
  logic [tavp_pkg::MagW-1:0]     window_peak;
  logic [tavp_pkg::MmsW-1:0]     window_peak_mms2;
  logic [tavp_pkg::PosW-1:0]     sample_number;
  logic                          last;

  modport source (output valid, magnitude, magnitude_mms2, window_peak, window_peak_mms2,
                  sample_number, last, input ready);
  modport sink   (input valid, magnitude, magnitude_mms2, window_peak, window_peak_mms2,
                  sample_number, last, output ready);
endinterface

[hdl/triggered_accel_window_peak.sv]
// A sample inside an open window goes through the 13-step serial square sum, the 13-step
// serial square root and the conversion to mm/s^2 before it is shown on the output; a new
// item is taken only after that sequence ends, and a tap event gives no result.
// A pending result waits in the output register while the next item is taken in.
// Reset (rst_ni, asynchronous, active low) closes the window, clears the count and the peak,
// and loads window_length = 256 and trigger_mask = 0x40.
module triggered_accel_window_peak (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tavp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tavp_pkg::CfgDataW-1:0]  cfg_data_i,
  tavp_in_if.sink                        in_i,
  tavp_out_if.source                     out_o
);

  // Control sequence for one sample: wait for the magnitude unit, convert the
  // new magnitude to mm/s^2, then load the output register when it is free.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StCalc = 3'b010,
    StConv = 3'b100
  } top_state_e;

  top_state_e state_q, state_d;

  // Configuration registers.
  logic [tavp_pkg::LenW-1:0] window_length_q;
  logic [tavp_pkg::SrcW-1:0] trigger_mask_q;

  // Window state.
  logic                       window_open_q, window_open_d;
  logic [tavp_pkg::LenW-1:0]  samples_taken_q, samples_taken_d;
  logic [tavp_pkg::MagW-1:0]  peak_q, peak_d;
  logic [tavp_pkg::MmsW-1:0]  peak_mms_q, peak_mms_d;

  // Converted magnitude of the sample under work.
  logic [tavp_pkg::MmsW-1:0]  mms_q;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic [tavp_pkg::MagW-1:0]  out_mag_q;
  logic [tavp_pkg::MmsW-1:0]  out_mag_mms_q;
  logic [tavp_pkg::MagW-1:0]  out_peak_q;
  logic [tavp_pkg::MmsW-1:0]  out_peak_mms_q;
  logic [tavp_pkg::PosW-1:0]  out_pos_q;
  logic                       out_last_q;

  tavp_pkg::mag_status_t      mag_stat;
  logic                       in_xfer;
  logic                       mag_start;
  logic                       tap_hit;
  logic                       out_load;
  logic                       is_last;
  logic                       new_peak;
  logic [tavp_pkg::LenW:0]    len_eff;
  logic [tavp_pkg::LenW:0]    pos_inc;
  logic [tavp_pkg::ProdW-1:0] prod;

  // Items are taken only between samples; the output register keeps the
  // previous result meanwhile, so a new item can be taken while it is pending.
  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign tap_hit    = (in_i.irq_src & trigger_mask_q) != '0;
  assign mag_start  = in_xfer && (in_i.cmd == tavp_pkg::CmdSample) && window_open_q;

  tavp_mag u_mag (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mag_start),
    .x_i      (in_i.sample_x),
    .y_i      (in_i.sample_y),
    .z_i      (in_i.sample_z),
    .status_o (mag_stat)
  );

  // Rounded fixed-point scale from sensor LSBs to mm/s^2.
  assign prod = tavp_pkg::ProdW'(mag_stat.root) * tavp_pkg::ProdW'(tavp_pkg::MmsFactor)
              + tavp_pkg::ProdW'(1 << (tavp_pkg::MmsShift - 1));

  // A programmed length of zero acts as one; lengths past the longest window saturate.
  always_comb begin
    if (window_length_q == '0) begin
      len_eff = (tavp_pkg::LenW+1)'(1);
    end else if ((tavp_pkg::LenW+1)'(window_length_q)
                 > (tavp_pkg::LenW+1)'(tavp_pkg::MaxWindow)) begin
      len_eff = (tavp_pkg::LenW+1)'(tavp_pkg::MaxWindow);
    end else begin
      len_eff = (tavp_pkg::LenW+1)'(window_length_q);
    end
  end

  assign pos_inc  = (tavp_pkg::LenW+1)'(samples_taken_q) + 1'b1;
  assign is_last  = pos_inc >= len_eff;
  assign new_peak = mag_stat.root > peak_q;
  assign out_load = (state_q == StConv) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d         = state_q;
    window_open_d   = window_open_q;
    samples_taken_d = samples_taken_q;
    peak_d          = peak_q;
    peak_mms_d      = peak_mms_q;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_i.cmd == tavp_pkg::CmdTap) begin
            // A matching tap opens or restarts the window.
            if (tap_hit) begin
              window_open_d   = 1'b1;
              samples_taken_d = '0;
              peak_d          = '0;
              peak_mms_d      = '0;
            end
          end else if (window_open_q) begin
            state_d = StCalc;
          end
        end
      end
      StCalc: begin
        if (mag_stat.done) begin
          state_d = StConv;
        end
      end
      StConv: begin
        if (out_load) begin
          state_d         = StIdle;
          samples_taken_d = tavp_pkg::LenW'(pos_inc);
          if (is_last) begin
            window_open_d = 1'b0;
          end
          if (new_peak) begin
            peak_d     = mag_stat.root;
            peak_mms_d = mms_q;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StIdle;
      window_length_q <= tavp_pkg::WindowLengthRst;
      trigger_mask_q  <= tavp_pkg::TriggerMaskRst;
      window_open_q   <= 1'b0;
      samples_taken_q <= '0;
      peak_q          <= '0;
      peak_mms_q      <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      window_open_q   <= window_open_d;
      samples_taken_q <= samples_taken_d;
      peak_q          <= peak_d;
      peak_mms_q      <= peak_mms_d;
      out_valid_q     <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tavp_pkg::CfgWindowLength: window_length_q <= cfg_data_i[tavp_pkg::LenW-1:0];
          tavp_pkg::CfgTriggerMask:  trigger_mask_q  <= cfg_data_i[tavp_pkg::SrcW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == StCalc && mag_stat.done) begin
      mms_q <= prod[tavp_pkg::MmsShift +: tavp_pkg::MmsW];
    end
    if (out_load) begin
      out_mag_q      <= mag_stat.root;
      out_mag_mms_q  <= mms_q;
      out_peak_q     <= new_peak ? mag_stat.root : peak_q;
      out_peak_mms_q <= new_peak ? mms_q : peak_mms_q;
      out_pos_q      <= samples_taken_q[tavp_pkg::PosW-1:0];
      out_last_q     <= is_last;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.magnitude        = out_mag_q;
  assign out_o.magnitude_mms2   = out_mag_mms_q;
  assign out_o.window_peak      = out_peak_q;
  assign out_o.window_peak_mms2 = out_peak_mms_q;
  assign out_o.sample_number    = out_pos_q;
  assign out_o.last             = out_last_q;

  // A result appears only at the end of a sample's sequence.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StConv))
    else $error("result shown without a finished sample");

  // The magnitude unit finishes only while the sequence waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_stat.done |-> (state_q == StCalc))
    else $error("magnitude unit finished outside a sample");

  // The reported peak never falls below the magnitude of the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_peak_q >= out_mag_q))
    else $error("window peak below sample magnitude");

  // An open window never holds more samples than the longest window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    window_open_q |-> ((tavp_pkg::LenW+1)'(samples_taken_q)
                       < (tavp_pkg::LenW+1)'(tavp_pkg::MaxWindow)))
    else $error("sample count ran past the window");

endmodule

[hdl/tavp_mag.sv]
// Bit-serial vector magnitude: floor(sqrt(x^2 + y^2 + z^2)).
module tavp_mag (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [tavp_pkg::AxisW-1:0]     x_i,
  input  logic signed [tavp_pkg::AxisW-1:0]     y_i,
  input  logic signed [tavp_pkg::AxisW-1:0]     z_i,
  output tavp_pkg::mag_status_t                 status_o
);

  typedef enum logic [2:0] {
    MagIdle = 3'b001,
    MagSqr  = 3'b010,
    MagRoot = 3'b100
  } mag_state_e;

  localparam int RemW = tavp_pkg::MagW + 1;
  localparam int ExtW = RemW + 2;

  mag_state_e state_q, state_d;
  logic [tavp_pkg::StepCntW-1:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic [tavp_pkg::AxisW-1:0] ax_q, ay_q, az_q;
  logic [tavp_pkg::AxisW-1:0] mx_q, my_q, mz_q;
  logic [tavp_pkg::SumW-1:0]  acc_q, acc_d;
  logic [RemW-1:0]            rem_q, rem_d;
  logic [tavp_pkg::MagW-1:0]  root_q, root_d;

  logic [tavp_pkg::AxisW-1:0] abs_x, abs_y, abs_z;
  logic [ExtW-1:0]            rem_ext, trial;
  logic                       fits;

  assign abs_x = x_i[tavp_pkg::AxisW-1] ? (~x_i + 1'b1) : x_i;
  assign abs_y = y_i[tavp_pkg::AxisW-1] ? (~y_i + 1'b1) : y_i;
  assign abs_z = z_i[tavp_pkg::AxisW-1] ? (~z_i + 1'b1) : z_i;

  // One radicand digit pair enters the remainder per step.
  assign rem_ext = {rem_q, acc_q[tavp_pkg::SumW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign fits    = rem_ext >= trial;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (state_q)
      MagIdle: begin
        if (start_i) begin
          state_d = MagSqr;
          cnt_d   = '0;
          acc_d   = '0;
        end
      end
      MagSqr: begin
        // MSB-first shift-and-add of all three squares into one sum.
        acc_d = (acc_q << 1)
              + tavp_pkg::SumW'(mx_q[tavp_pkg::AxisW-1] ? ax_q : '0)
              + tavp_pkg::SumW'(my_q[tavp_pkg::AxisW-1] ? ay_q : '0)
              + tavp_pkg::SumW'(mz_q[tavp_pkg::AxisW-1] ? az_q : '0);
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == tavp_pkg::LastStep) begin
          state_d = MagRoot;
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
        end
      end
      MagRoot: begin
        acc_d  = acc_q << 2;
        rem_d  = fits ? RemW'(rem_ext - trial) : RemW'(rem_ext);
        root_d = {root_q[tavp_pkg::MagW-2:0], fits};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == tavp_pkg::LastStep) begin
          state_d = MagIdle;
          done_d  = 1'b1;
        end
      end
      default: state_d = MagIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MagIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    if (state_q == MagIdle && start_i) begin
      ax_q <= abs_x;
      ay_q <= abs_y;
      az_q <= abs_z;
      mx_q <= abs_x;
      my_q <= abs_y;
      mz_q <= abs_z;
    end else if (state_q == MagSqr) begin
      mx_q <= mx_q << 1;
      my_q <= my_q << 1;
      mz_q <= mz_q << 1;
    end
  end

  assign status_o.done = done_q;
  assign status_o.root = root_q;

endmodule
